@@ sv/swk_pkg.sv @@
// ----------------------------------------------------------------------------
// Swerve kinematics package
// Shared constants and the arctangent table for the CORDIC lanes.
// ----------------------------------------------------------------------------
package swk_pkg;

	// Default angle width and CORDIC depth.
	localparam int ANGLE_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	// Width of the CORDIC x and y datapath, enough for the grown magnitude.
	localparam int XW = 36;

	// 0.7071 in Q0.16, and the inverse CORDIC gain in Q0.32.
	localparam logic [16:0] DIAG_Q16     = 17'd46341;
	localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131495;

	// Reset value of the wheel speed scale.
	localparam logic [15:0] SPEED_FACTOR_RST = 16'd256;

	// atan(2^-i) in units of 2^32 per full turn.
	localparam logic [31:0] ATAN_TAB [0:23] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

endpackage

@@ sv/swk_cordic.sv @@
// ----------------------------------------------------------------------------
// Swerve kinematics CORDIC lane
// Vectoring CORDIC, one iteration per register stage, driving y toward zero.
// ----------------------------------------------------------------------------
module swk_cordic #(
	parameter int STEPS = swk_pkg::CORDIC_STEPS_DEF
) (
	input  logic                          clk,
	input  logic [STEPS-1:0]              en,
	input  logic signed [swk_pkg::XW-1:0] x_in,
	input  logic signed [swk_pkg::XW-1:0] y_in,
	input  logic [31:0]                   z_in,
	output logic signed [swk_pkg::XW-1:0] x_out,
	output logic [31:0]                   z_out
);

	localparam int XW = swk_pkg::XW;

	logic signed [XW-1:0] x_s [0:STEPS];
	logic signed [XW-1:0] y_s [0:STEPS-1];
	logic [31:0]          z_s [0:STEPS];

	assign x_s[0] = x_in;
	assign y_s[0] = y_in;
	assign z_s[0] = z_in;

	// One micro-rotation per stage.
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [XW-1:0] ysh;
		logic                 yneg;

		assign ysh  = y_s[i] >>> i;
		assign yneg = y_s[i][XW-1];

		always_ff @(posedge clk) begin
			if (en[i]) begin
				if (!yneg) begin
					x_s[i+1] <= x_s[i] + ysh;
					z_s[i+1] <= z_s[i] + swk_pkg::ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] - ysh;
					z_s[i+1] <= z_s[i] - swk_pkg::ATAN_TAB[i];
				end
			end
		end

		// The residual y of the final step is not needed.
		if (i < STEPS - 1) begin : g_y
			logic signed [XW-1:0] xsh;

			assign xsh = x_s[i] >>> i;

			always_ff @(posedge clk) begin
				if (en[i]) begin
					y_s[i+1] <= yneg ? (y_s[i] + xsh) : (y_s[i] - xsh);
				end
			end
		end
	end

	assign x_out = x_s[STEPS];
	assign z_out = z_s[STEPS];

endmodule

@@ sv/swerve_module_kinematics_top.sv @@
// ----------------------------------------------------------------------------
// Swerve module kinematics
// Four-module swerve inverse kinematics: CORDIC angle and magnitude per
// module, nearest-orientation choice with wheel reversal, speed scaling.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  s_*      in         chassis command and four measured steering angles
//  m_*      out        four steering targets, four wheel speeds, idle flag
//  cfg_*    in         speed_factor write
//
// The pipeline has CORDIC_STEPS + 5 register stages, set by the
// one-iteration-per-stage CORDIC lanes, and one beat is accepted every cycle
// unless a stalled output has filled every stage.
// Reset clears all valid bits, the held targets and sets speed_factor to 256.
// A stall at the output backs up only as far as the pipeline is full; bubbles
// are closed up so s_tready stays high while any stage is empty.
module swerve_module_kinematics_top #(
	parameter int ANGLE_BITS   = swk_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = swk_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// forward_speed, side_speed, turn_speed, front_left_angle,
	// front_right_angle, back_left_angle, back_right_angle (16 bits each)
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,
	// front_left_target .. back_right_target (16 bits each), then
	// front_left_speed .. back_right_speed (24 bits each)
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [159:0] m_tdata,
	// idle_command
	output logic         m_tuser,
	input  logic         cfg_wr_en,
	input  logic [15:0]  cfg_wr_data
);

	localparam int AB = ANGLE_BITS;
	localparam int C  = CORDIC_STEPS;
	localparam int N  = C + 5;
	localparam int XW = swk_pkg::XW;
	localparam logic [AB-1:0] HALF = AB'(1) << (AB - 1);
	localparam logic [AB:0]   FULL = (AB+1)'(1) << AB;
	localparam logic [31:0]   RND  = 32'(1) << (31 - AB);

	// Configuration register.
	logic [15:0] speed_factor_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_factor_q <= swk_pkg::SPEED_FACTOR_RST;
		end else if (cfg_wr_en) begin
			speed_factor_q <= cfg_wr_data;
		end
	end

	// Stage valids and per-stage advance: a stage loads when empty or draining.
	logic [N-1:0] v_q;
	logic [N-1:0] en;
	always_comb begin
		en[N-1] = !v_q[N-1] || m_tready;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= s_tvalid;
			end
			for (int k = 1; k < N; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign s_tready = en[0];

	// Stage 1: unpack, diagonal product of the turn rate, idle detect.
	logic signed [15:0] vx_in, vy_in, vw_in;
	logic signed [32:0] p_c;
	assign vx_in = s_tdata[15:0];
	assign vy_in = s_tdata[31:16];
	assign vw_in = s_tdata[47:32];
	assign p_c   = 33'(vw_in) * $signed({16'd0, swk_pkg::DIAG_Q16});

	logic signed [15:0]  vx_s1, vy_s1;
	logic signed [32:0]  p_s1;
	logic [3:0][AB-1:0]  cur_s1;
	logic                idle_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			vx_s1   <= vx_in;
			vy_s1   <= vy_in;
			p_s1    <= p_c;
			idle_s1 <= (vx_in == '0) && (vy_in == '0) && (vw_in == '0);
			for (int k = 0; k < 4; k++) begin
				cur_s1[k] <= AB'(32'(signed'(s_tdata[48 + 16*k +: 16])));
			end
		end
	end

	// Stage 2: module vectors, left half-plane turned by half a turn.
	logic signed [XW-1:0] x_s2 [4];
	logic signed [XW-1:0] y_s2 [4];
	logic [31:0]          z_s2 [4];
	logic [3:0][AB-1:0]   cur_c [0:C];
	logic                 idle_c [0:C];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < 4; k++) begin
				logic signed [XW-1:0] bx, by, pp, xc, yc;
				bx = XW'(signed'({vx_s1, 16'd0}));
				by = XW'(signed'({vy_s1, 16'd0}));
				pp = XW'(p_s1);
				yc = (k < 2) ? (by + pp) : (by - pp);
				xc = ((k % 2) == 1) ? (bx + pp) : (bx - pp);
				if (xc[XW-1]) begin
					x_s2[k] <= -xc;
					y_s2[k] <= -yc;
					z_s2[k] <= 32'h80000000;
				end else begin
					x_s2[k] <= xc;
					y_s2[k] <= yc;
					z_s2[k] <= '0;
				end
			end
			cur_c[0]  <= cur_s1;
			idle_c[0] <= idle_s1;
		end
	end

	// CORDIC stages, with the side data carried alongside.
	logic signed [XW-1:0] xo [4];
	logic [31:0]          zo [4];

	for (genvar k = 0; k < 4; k++) begin : g_lane
		swk_cordic #(.STEPS(C)) u_cordic (
			.clk   (clk),
			.en    (en[C+1:2]),
			.x_in  (x_s2[k]),
			.y_in  (y_s2[k]),
			.z_in  (z_s2[k]),
			.x_out (xo[k]),
			.z_out (zo[k])
		);
	end

	for (genvar i = 0; i < C; i++) begin : g_side
		always_ff @(posedge clk) begin
			if (en[2+i]) begin
				cur_c[i+1]  <= cur_c[i];
				idle_c[i+1] <= idle_c[i];
			end
		end
	end

	// Stage 3: round the angle, remove the CORDIC gain.
	logic [3:0][AB-1:0] ang_s3, cur_s3;
	logic [59:0]        prod_s3 [4];
	logic               idle_s3;

	always_ff @(posedge clk) begin
		if (en[C+2]) begin
			for (int k = 0; k < 4; k++) begin
				logic [31:0] zr;
				zr = zo[k] + RND;
				ang_s3[k]  <= zr[31 -: AB];
				prod_s3[k] <= 60'(xo[k][XW-1:8]) * 60'(swk_pkg::INV_GAIN_Q32);
			end
			cur_s3  <= cur_c[C];
			idle_s3 <= idle_c[C];
		end
	end

	// Stage 4: nearest orientation, speed scaling.
	logic [3:0][AB-1:0] tgt_s4;
	logic [3:0]         flip_s4;
	logic [43:0]        spd_s4 [4];
	logic               idle_s4;

	always_ff @(posedge clk) begin
		if (en[C+3]) begin
			for (int k = 0; k < 4; k++) begin
				logic [AB-1:0] alt, d1, d2;
				logic [AB:0]   m1, m2;
				alt = ang_s3[k] + HALF;
				d1  = ang_s3[k] - cur_s3[k];
				d2  = alt - cur_s3[k];
				m1  = d1[AB-1] ? (FULL - {1'b0, d1}) : {1'b0, d1};
				m2  = d2[AB-1] ? (FULL - {1'b0, d2}) : {1'b0, d2};
				flip_s4[k] <= !(m1 < m2);
				tgt_s4[k]  <= (m1 < m2) ? ang_s3[k] : alt;
				spd_s4[k]  <= 44'(prod_s3[k][59:32]) * 44'(speed_factor_q);
			end
			idle_s4 <= idle_s3;
		end
	end

	// Stage 5: saturate, apply reversal, hold targets on an idle command.
	logic [3:0][AB-1:0] held_q;
	logic [15:0]        tgt_o [4];
	logic [23:0]        spd_o [4];
	logic               idle_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (en[N-1] && v_q[N-2] && !idle_s4) begin
			held_q <= tgt_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en[N-1]) begin
			for (int k = 0; k < 4; k++) begin
				logic [27:0] sp;
				logic [23:0] sv;
				sp = spd_s4[k][43:16];
				if (flip_s4[k]) begin
					sv = (sp >= 28'd8388608) ? 24'h800000 : (24'd0 - sp[23:0]);
				end else begin
					sv = (sp >= 28'd8388607) ? 24'h7FFFFF : sp[23:0];
				end
				if (idle_s4) begin
					tgt_o[k] <= 16'(32'(signed'(held_q[k])));
					spd_o[k] <= '0;
				end else begin
					tgt_o[k] <= 16'(32'(signed'(tgt_s4[k])));
					spd_o[k] <= sv;
				end
			end
			idle_o <= idle_s4;
		end
	end

	assign m_tvalid = v_q[N-1];
	assign m_tdata  = {spd_o[3], spd_o[2], spd_o[1], spd_o[0],
	                   tgt_o[3], tgt_o[2], tgt_o[1], tgt_o[0]};
	assign m_tuser  = idle_o;

	// An idle beat carries zero wheel speeds.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[159:64] == '0)
		else $error("idle beat with nonzero wheel speed");

	// The input only backs up when the output beat is waiting.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output free");

	// An idle beat never carries a saturated front left speed.
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[87:64] != 24'h7FFFFF || !m_tuser)
		else $error("saturated speed on idle beat");

endmodule

@@ dv/tb_swerve_module_kinematics_top.sv @@
// ----------------------------------------------------------------------------
// Swerve module kinematics testbench
// Drives chassis commands with random bursts and output stalls, predicts each
// result beat with a fixed-point model of the four module lanes, and checks
// every returned beat field by field across several speed scale settings.
// ----------------------------------------------------------------------------
module tb_swerve_module_kinematics_top;

	localparam int LATENCY   = swk_pkg::CORDIC_STEPS_DEF + 5;
	localparam int STALL_MAX = 4000;
	localparam int LONG_HOLD = 300;

	// Receiver stall styles.
	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

	// One command beat: fields 0..6 from the lowest bits up.
	typedef logic [6:0][15:0] command_t;

	// One result beat as the predictor sees it.
	typedef struct {
		logic [15:0] target [4];
		logic [23:0] speed [4];
		logic        idle;
	} wheel_set_t;

	// Directed table row; fixed_check marks rows with a typed-in result.
	typedef struct {
		command_t   cmd;
		bit         fixed_check;
		wheel_set_t fixed;
	} vector_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [159:0] m_tdata;
	logic         m_tuser;
	logic         cfg_wr_en = 1'b0;
	logic [15:0]  cfg_wr_data = '0;

	swerve_module_kinematics_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always #2 clk = ~clk;

	// Predictor state and scoreboard.
	logic [15:0] speed_scale;
	logic [15:0] last_target [4];
	wheel_set_t  pending_wheels [$];
	int          error_count = 0;
	int          burst_left = 0;
	rx_style_t   rx_style = RX_ALWAYS;
	bit          hold_request = 1'b0;
	int          hold_left = 0;
	int          rx_cycle = 0;
	int          quiet_cycles = 0;

	// Wrapped distance between two binary angles, as a magnitude.
	function automatic logic [16:0] wrap_distance(input logic [15:0] d);
		return d[15] ? 17'h10000 - {1'b0, d} : {1'b0, d};
	endfunction

	// Vectoring CORDIC: rounded angle and magnitude in Q.8.
	function automatic void vector_angle(input longint xi, input longint yi,
			output logic [15:0] ang, output longint unsigned mag);
		longint      x, y, xs, ys;
		logic [31:0] z;
		x = xi;
		y = yi;
		z = '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h80000000;
		end
		for (int i = 0; i < swk_pkg::CORDIC_STEPS_DEF; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + swk_pkg::ATAN_TAB[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - swk_pkg::ATAN_TAB[i];
			end
		end
		z = z + 32'h8000;
		ang = z[31:16];
		mag = ((longint'(unsigned'(x)) >> 8) * 64'(swk_pkg::INV_GAIN_Q32)) >> 32;
	endfunction

	// Work out the wheel set for one accepted command and update held targets.
	function automatic wheel_set_t predict_wheels(input command_t c);
		wheel_set_t        w;
		longint            vx, vy, vw, p, xc, yc, s;
		longint unsigned   mag, spd;
		logic [15:0]       th, alt, cur, tgt;
		bit                flip;
		vx = longint'($signed(c[0]));
		vy = longint'($signed(c[1]));
		vw = longint'($signed(c[2]));
		if (vx == 0 && vy == 0 && vw == 0) begin
			for (int k = 0; k < 4; k++) begin
				w.target[k] = last_target[k];
				w.speed[k] = '0;
			end
			w.idle = 1'b1;
			return w;
		end
		p = vw * 46341;
		for (int k = 0; k < 4; k++) begin
			yc = vy * 65536 + ((k < 2) ? p : -p);
			xc = vx * 65536 + ((k % 2 == 1) ? p : -p);
			cur = c[3 + k];
			vector_angle(xc, yc, th, mag);
			alt = th + 16'h8000;
			flip = !(wrap_distance(th - cur) < wrap_distance(alt - cur));
			tgt = flip ? alt : th;
			last_target[k] = tgt;
			spd = (mag * speed_scale) >> 16;
			if (spd > 64'd8388608)
				spd = 64'd8388608;
			s = flip ? -longint'(spd) : longint'(spd);
			if (s > 8388607)
				s = 8388607;
			w.target[k] = tgt;
			w.speed[k] = s[23:0];
		end
		w.idle = 1'b0;
		return w;
	endfunction

	// Offer one command beat; bursts of random length with random gaps.
	task automatic send_command(input command_t c, input bit gaps_on);
		int gap;
		if (burst_left == 0) begin
			gap = gaps_on ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		do @(posedge clk); while (!s_tready);
		pending_wheels.push_back(predict_wheels(c));
		burst_left--;
	endtask

	// Wait for the pipeline to drain, then let the tail settle.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_wheels.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Register write; only called with the block idle.
	task automatic write_speed_scale(input logic [15:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		speed_scale = v;
	endtask

	function automatic command_t random_command();
		command_t c;
		int       pick;
		for (int f = 0; f < 7; f++)
			c[f] = 16'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			c[0] = '0;
			c[1] = '0;
			c[2] = '0;
		end else if (pick < 30) begin
			for (int f = 0; f < 3; f++)
				c[f] = 16'($signed($urandom_range(0, 600)) - 300);
		end else if (pick < 40) begin
			c[$urandom_range(0, 2)] = '0;
			c[$urandom_range(0, 2)] = '0;
		end
		return c;
	endfunction

	// Receiver: stall styles, one long hold-off on request, and the checker.
	always @(posedge clk) begin
		wheel_set_t exp_w;
		logic [15:0] got_t;
		logic [23:0] got_s;
		rx_cycle <= rx_cycle + 1;
		if (m_tvalid && m_tready) begin
			if (pending_wheels.size() == 0) begin
				$display("%0t: result beat with nothing expected, data %h", $time, m_tdata);
				error_count++;
			end else begin
				exp_w = pending_wheels.pop_front();
				for (int k = 0; k < 4; k++) begin
					got_t = m_tdata[16 * k +: 16];
					got_s = m_tdata[64 + 24 * k +: 24];
					if (got_t !== exp_w.target[k]) begin
						$display("%0t: target %0d expected %h actual %h",
							$time, k, exp_w.target[k], got_t);
						error_count++;
					end
					if (got_s !== exp_w.speed[k]) begin
						$display("%0t: speed %0d expected %h actual %h",
							$time, k, exp_w.speed[k], got_s);
						error_count++;
					end
				end
				if (m_tuser !== exp_w.idle) begin
					$display("%0t: idle flag expected %b actual %b", $time, exp_w.idle, m_tuser);
					error_count++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_request) begin
			hold_request <= 1'b0;
			hold_left <= LONG_HOLD;
			m_tready <= 1'b0;
		end else begin
			case (rx_style)
				RX_ALWAYS: m_tready <= 1'b1;
				RX_RANDOM: m_tready <= ($urandom_range(0, 99) < 60);
				default:   m_tready <= ((rx_cycle % 11) < 7);
			endcase
		end
	end

	// Watchdog on cycles with no beat accepted on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_MAX) begin
			$display("tb_swerve_module_kinematics_top: errors");
			$finish;
		end
	end

	function automatic vector_row_t row(input int fwd, input int side, input int turn,
			input logic [15:0] a0, input logic [15:0] a1,
			input logic [15:0] a2, input logic [15:0] a3);
		vector_row_t r;
		r.cmd = {a3, a2, a1, a0, 16'(turn), 16'(side), 16'(fwd)};
		r.fixed_check = 1'b0;
		return r;
	endfunction

	initial begin
		vector_row_t     vectors [$];
		vector_row_t     r;
		wheel_set_t      w;
		logic [15:0]     scales [6];

		speed_scale = swk_pkg::SPEED_FACTOR_RST;
		for (int k = 0; k < 4; k++)
			last_target[k] = '0;

		// Directed vectors. The first idle command after reset has a known result.
		r = row(0, 0, 0, 16'h1234, 16'h8000, 16'h7FFF, 16'hFFFF);
		r.fixed_check = 1'b1;
		for (int k = 0; k < 4; k++) begin
			r.fixed.target[k] = '0;
			r.fixed.speed[k] = '0;
		end
		r.fixed.idle = 1'b1;
		vectors.push_back(r);
		vectors.push_back(row(32767, 0, 0, 0, 0, 0, 0));
		vectors.push_back(row(-32768, 0, 0, 0, 0, 0, 0));
		vectors.push_back(row(0, 32767, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
		vectors.push_back(row(0, -32768, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		vectors.push_back(row(0, 0, 32767, 0, 16'h4000, 16'h8000, 16'hC000));
		vectors.push_back(row(0, 0, -32768, 16'hFFFF, 16'h0001, 16'h8001, 16'h7FFE));
		vectors.push_back(row(-32768, -32768, -32768, 16'h8000, 0, 16'h7FFF, 16'hFFFF));
		vectors.push_back(row(32767, 32767, 32767, 16'h2000, 16'hA000, 16'h6000, 16'hE000));
		vectors.push_back(row(-32768, 32767, 0, 0, 0, 0, 0));
		// Tie between the plain and flipped angles picks the flipped one.
		vectors.push_back(row(256, 0, 0, 16'h4000, 16'hC000, 16'h4000, 16'hC000));
		vectors.push_back(row(0, 256, 0, 16'h0000, 16'h8000, 16'h0000, 16'h8000));
		// Idle after motion holds the last targets.
		vectors.push_back(row(0, 0, 0, 16'h5555, 16'hAAAA, 0, 16'hFFFF));
		vectors.push_back(row(1, 0, 0, 0, 0, 0, 0));
		vectors.push_back(row(0, 0, 1, 0, 0, 0, 0));
		vectors.push_back(row(0, 0, 0, 0, 0, 0, 0));
		vectors.push_back(row(-1, -1, -1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		scales[0] = 16'd256;
		scales[1] = 16'd65535;
		scales[2] = 16'd0;
		scales[3] = 16'd1;
		scales[4] = 16'($urandom());
		scales[5] = 16'd384;

		// Directed pass at the reset scale, the first row checked against typed values.
		rx_style = RX_RANDOM;
		foreach (vectors[i]) begin
			if (vectors[i].fixed_check) begin
				w = predict_wheels(vectors[i].cmd);
				for (int k = 0; k < 4; k++)
					if (w.target[k] !== vectors[i].fixed.target[k] ||
							w.speed[k] !== vectors[i].fixed.speed[k]) begin
						$display("%0t: table row %0d expected %h/%h actual %h/%h", $time, i,
							vectors[i].fixed.target[k], vectors[i].fixed.speed[k],
							w.target[k], w.speed[k]);
						error_count++;
					end
				for (int k = 0; k < 4; k++)
					last_target[k] = '0;
			end
			send_command(vectors[i].cmd, 1'b1);
		end
		drain_results();

		// Random phases, one speed scale each; the sender waits for a full drain
		// between phases.
		for (int ph = 0; ph < 6; ph++) begin
			write_speed_scale(scales[ph]);
			rx_style = rx_style_t'(ph % 3);
			if (ph == 1)
				hold_request = 1'b1;
			for (int n = 0; n < 250; n++)
				send_command(random_command(), ph != 3);
			drain_results();
		end

		if (error_count == 0 && pending_wheels.size() == 0)
			$display("tb_swerve_module_kinematics_top: clean");
		else
			$display("tb_swerve_module_kinematics_top: errors");
		$finish;
	end

endmodule
